// ===== src/gn3_pkg.sv =====
`timescale 1ns / 1ps

package gn3_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] FUNC_PERM = 2'd0;
    localparam logic [1:0] FUNC_GRAD = 2'd1;
    localparam logic [1:0] FUNC_EVAL = 2'd2;

    // one gradient entry: x, y, z packed high to low
    localparam int GRAD_W = 48;
    // fade weight 0..65536
    localparam int U_W = 17;
    localparam int ONE_Q16 = 65536;

    typedef struct packed {
        logic               perm_we;
        logic               grad_we;
        logic [7:0]         index;
        logic [7:0]         perm_value;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_load;

endpackage

// ===== src/gn3_ram.sv =====
`timescale 1ns / 1ps

module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gn3_hash.sv =====
`timescale 1ns / 1ps

module gn3_hash #(
    parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  gn3_pkg::t_load                i_load,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_x0,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_x1,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_y0,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_y1,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_z0,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_z1,
    output logic [gn3_pkg::GRAD_W-1:0]    o_grad [8]
);
    import gn3_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);

    logic [AW-1:0]     w_waddr;
    logic [GRAD_W-1:0] w_gdata;
    logic [AW-1:0]     w_ra0 [2];
    logic [AW-1:0]     w_ra1 [4];
    logic [AW-1:0]     w_ra2 [8];
    logic [AW-1:0]     w_ga  [8];
    logic [7:0]        w_pd0 [2];
    logic [7:0]        w_pd1 [4];
    logic [7:0]        w_pd2 [8];
    logic [AW-1:0]     r_y1  [2];
    logic [AW-1:0]     r_z1  [2];
    logic [AW-1:0]     r_z2  [2];

    assign w_waddr  = AW'({{AW{1'b0}}, i_load.index});
    assign w_gdata  = {i_load.gx, i_load.gy, i_load.gz};
    assign w_ra0[0] = i_x0;
    assign w_ra0[1] = i_x1;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_y1[0] <= i_y0;
            r_y1[1] <= i_y1;
            r_z1[0] <= i_z0;
            r_z1[1] <= i_z1;
            r_z2    <= r_z1;
        end
    end

    // corner index k = {x, y, z}
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                w_ra1[i*2+j] = AW'({{AW{1'b0}}, w_pd0[i]}) + r_y1[j];
            end
        end
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 2; k++) begin
                w_ra2[j*2+k] = AW'({{AW{1'b0}}, w_pd1[j]}) + r_z2[k];
            end
        end
        for (int k = 0; k < 8; k++) begin
            w_ga[k] = AW'({{AW{1'b0}}, w_pd2[k]});
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_perm0
        gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_load.perm_we),
            .i_waddr(w_waddr),
            .i_wdata(i_load.perm_value),
            .i_re   (i_adv),
            .i_raddr(w_ra0[g]),
            .o_rdata(w_pd0[g])
        );
    end

    for (genvar g = 0; g < 4; g++) begin : g_perm1
        gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_load.perm_we),
            .i_waddr(w_waddr),
            .i_wdata(i_load.perm_value),
            .i_re   (i_adv),
            .i_raddr(w_ra1[g]),
            .o_rdata(w_pd1[g])
        );
    end

    for (genvar g = 0; g < 8; g++) begin : g_perm2
        gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_load.perm_we),
            .i_waddr(w_waddr),
            .i_wdata(i_load.perm_value),
            .i_re   (i_adv),
            .i_raddr(w_ra2[g]),
            .o_rdata(w_pd2[g])
        );
    end

    for (genvar g = 0; g < 8; g++) begin : g_grad
        gn3_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_load.grad_we),
            .i_waddr(w_waddr),
            .i_wdata(w_gdata),
            .i_re   (i_adv),
            .i_raddr(w_ga[g]),
            .o_rdata(o_grad[g])
        );
    end

endmodule

// ===== src/gn3_fade.sv =====
`timescale 1ns / 1ps

module gn3_fade (
    input  logic                   i_clk,
    input  logic                   i_adv,
    input  logic [15:0]            i_t,
    output logic [15:0]            o_t,
    output logic [gn3_pkg::U_W-1:0] o_u
);
    import gn3_pkg::*;

    logic [31:0]        w_p2, w_p3, w_p4, w_p5;
    logic [15:0]        r_t1, r_t2, r_t3, r_t4;
    logic [15:0]        r_q2, r_q3_2, r_q3_3, r_q3_4, r_q4_3, r_q4_4, r_q5_4;
    logic signed [21:0] w_a3, w_a4, w_a5, w_poly;
    logic [U_W-1:0]     r_u, n_u;

    assign w_p2 = 32'(i_t) * 32'(i_t);
    assign w_p3 = 32'(r_q2) * 32'(r_t1);
    assign w_p4 = 32'(r_q3_2) * 32'(r_t2);
    assign w_p5 = 32'(r_q4_3) * 32'(r_t3);

    assign w_a3   = signed'(22'(r_q3_4));
    assign w_a4   = signed'(22'(r_q4_4));
    assign w_a5   = signed'(22'(r_q5_4));
    assign w_poly = 22'sd6 * w_a5 - 22'sd15 * w_a4 + 22'sd10 * w_a3;

    always_comb begin
        priority if (w_poly < 22'sd0) begin
            n_u = '0;
        end else if (w_poly > 22'(ONE_Q16)) begin
            n_u = U_W'(ONE_Q16);
        end else begin
            n_u = U_W'(w_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t1   <= i_t;
            r_q2   <= w_p2[31:16];
            r_t2   <= r_t1;
            r_q3_2 <= w_p3[31:16];
            r_t3   <= r_t2;
            r_q3_3 <= r_q3_2;
            r_q4_3 <= w_p4[31:16];
            r_t4   <= r_t3;
            r_q3_4 <= r_q3_3;
            r_q4_4 <= r_q4_3;
            r_q5_4 <= w_p5[31:16];
            r_u    <= n_u;
        end
    end

    assign o_t = r_t4;
    assign o_u = r_u;

endmodule

// ===== src/gn3_interp.sv =====
`timescale 1ns / 1ps

module gn3_interp (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic [gn3_pkg::GRAD_W-1:0]  i_grad [8],
    input  logic [15:0]                 i_tx,
    input  logic [15:0]                 i_ty,
    input  logic [15:0]                 i_tz,
    input  logic [gn3_pkg::U_W-1:0]     i_u,
    input  logic [gn3_pkg::U_W-1:0]     i_v,
    input  logic [gn3_pkg::U_W-1:0]     i_w,
    output logic signed [15:0]          o_noise
);
    import gn3_pkg::*;

    localparam int PW = 34;
    localparam int CW = 36;
    localparam int RW = CW - 16;

    function automatic logic signed [CW-1:0] blend(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic [U_W-1:0]       u
    );
        logic signed [CW:0]       d;
        logic signed [CW+U_W+1:0] p;
        d = (CW+1)'(b) - (CW+1)'(a);
        p = d * signed'({1'b0, u});
        return a + CW'(p >>> 16);
    endfunction

    logic signed [17:0] w_off [3][2];
    logic signed [15:0] w_g   [8][3];
    logic signed [PW-1:0] r_prod [8][3];
    logic signed [CW-1:0] r_corner [8];
    logic signed [CW-1:0] r_xb [4];
    logic signed [CW-1:0] r_yb [2];
    logic signed [CW-1:0] r_zb;
    logic signed [RW-1:0] w_r;
    logic signed [15:0]   r_noise, n_noise;
    logic [U_W-1:0]       r_u6, r_v6, r_v7, r_w6, r_w7, r_w8;

    always_comb begin
        w_off[0][0] = signed'({2'b00, i_tx});
        w_off[1][0] = signed'({2'b00, i_ty});
        w_off[2][0] = signed'({2'b00, i_tz});
        for (int a = 0; a < 3; a++) begin
            w_off[a][1] = w_off[a][0] - 18'(ONE_Q16);
        end
        for (int k = 0; k < 8; k++) begin
            w_g[k][0] = signed'(i_grad[k][47:32]);
            w_g[k][1] = signed'(i_grad[k][31:16]);
            w_g[k][2] = signed'(i_grad[k][15:0]);
        end
    end

    assign w_r = RW'(r_zb >>> 16);

    always_comb begin
        priority if (w_r > RW'(32767)) begin
            n_noise = 16'sh7FFF;
        end else if (w_r < -RW'(32768)) begin
            n_noise = 16'sh8000;
        end else begin
            n_noise = 16'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // corner k = {x, y, z}: a set bit takes the far offset on that axis
            for (int k = 0; k < 8; k++) begin
                r_prod[k][0] <= PW'(w_g[k][0] * w_off[0][k/4]);
                r_prod[k][1] <= PW'(w_g[k][1] * w_off[1][(k/2)%2]);
                r_prod[k][2] <= PW'(w_g[k][2] * w_off[2][k%2]);
                r_corner[k]  <= CW'(r_prod[k][0]) + CW'(r_prod[k][1]) + CW'(r_prod[k][2]);
            end
            r_u6 <= i_u;
            r_v6 <= i_v;
            r_w6 <= i_w;
            for (int m = 0; m < 4; m++) begin
                r_xb[m] <= blend(r_corner[m], r_corner[4+m], r_u6);
            end
            r_v7 <= r_v6;
            r_w7 <= r_w6;
            for (int z = 0; z < 2; z++) begin
                r_yb[z] <= blend(r_xb[z], r_xb[2+z], r_v7);
            end
            r_w8    <= r_w7;
            r_zb    <= blend(r_yb[0], r_yb[1], r_w8);
            r_noise <= n_noise;
        end
    end

    assign o_noise = r_noise;

endmodule

// ===== src/gradient_noise_3d_unit.sv =====
`timescale 1ns / 1ps

// Channel   Valid         Stall          Payload
// input     i_in_valid    o_in_stall     i_func, i_table_index, i_perm_value,
//                                        i_grad_x/y/z, i_px/py/pz
// output    o_out_valid   i_out_stall    o_noise
//
// One item per cycle unless the pipeline is frozen or a load is held off. An evaluate
// item passes through the three chained permutation reads, the gradient read,
// the fade multiplier chain and the three blend stages before its noise is given.
// A load item writes every copy of its table at acceptance and gives no result; it is
// held off while an evaluate item still has table reads pending.
// The whole pipeline freezes while the output holds an item that is stalled.
// Reset clears the valid bits only; table contents are undefined until loaded.

module gradient_noise_3d_unit #(
    parameter int TABLE_SIZE = gn3_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_noise
);
    import gn3_pkg::*;

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int LAT = 10;

    logic               w_adv, w_is_load, w_take, w_eval;
    logic [LAT:1]       r_vld, n_vld;
    t_load              w_load;
    logic signed [31:0] w_pt [3];
    logic [AW-1:0]      w_c0 [3];
    logic [AW-1:0]      w_c1 [3];
    logic [15:0]        w_t  [3];
    logic [15:0]        w_t4 [3];
    logic [U_W-1:0]     w_u  [3];
    logic [GRAD_W-1:0]  w_grad [8];

    assign w_adv      = !(r_vld[LAT] && i_out_stall);
    assign w_is_load  = (i_func == FUNC_PERM) || (i_func == FUNC_GRAD);
    // hold a load until no evaluate item still reads the tables
    assign o_in_stall = !w_adv || (w_is_load && (|r_vld[3:1]));
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_eval     = w_take && (i_func == FUNC_EVAL);

    assign w_load.perm_we    = w_take && (i_func == FUNC_PERM);
    assign w_load.grad_we    = w_take && (i_func == FUNC_GRAD);
    assign w_load.index      = i_table_index;
    assign w_load.perm_value = i_perm_value;
    assign w_load.gx         = i_grad_x;
    assign w_load.gy         = i_grad_y;
    assign w_load.gz         = i_grad_z;

    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[LAT-1:1], w_eval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_pt[0] = i_px;
    assign w_pt[1] = i_py;
    assign w_pt[2] = i_pz;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic [63:0] w_ext;

        assign w_ext   = {{32{w_pt[g][31]}}, w_pt[g]};
        assign w_c0[g] = w_ext[FRAC_BITS +: AW];
        assign w_c1[g] = w_c0[g] + AW'(1);

        if (FRAC_BITS >= 16) begin : g_trunc
            assign w_t[g] = w_ext[FRAC_BITS-1 -: 16];
        end else begin : g_pad
            assign w_t[g] = {w_ext[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end

        gn3_fade u_fade (
            .i_clk(i_clk),
            .i_adv(w_adv),
            .i_t  (w_t[g]),
            .o_t  (w_t4[g]),
            .o_u  (w_u[g])
        );
    end

    gn3_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_load(w_load),
        .i_x0  (w_c0[0]),
        .i_x1  (w_c1[0]),
        .i_y0  (w_c0[1]),
        .i_y1  (w_c1[1]),
        .i_z0  (w_c0[2]),
        .i_z1  (w_c1[2]),
        .o_grad(w_grad)
    );

    gn3_interp u_interp (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_grad (w_grad),
        .i_tx   (w_t4[0]),
        .i_ty   (w_t4[1]),
        .i_tz   (w_t4[2]),
        .i_u    (w_u[0]),
        .i_v    (w_u[1]),
        .i_w    (w_u[2]),
        .o_noise(o_noise)
    );

    assign o_out_valid = r_vld[LAT];

    a_load_no_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load.perm_we || w_load.grad_we) |-> !(r_vld[1] || r_vld[2] || r_vld[3]))
        else $error("table write while an evaluate item reads the tables");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |=> r_vld[1])
        else $error("accepted evaluate item lost at entry");

    a_no_double_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_eval, w_load.perm_we, w_load.grad_we}))
        else $error("one item decoded as more than one function");

endmodule
